@@ rtl/spq_pkg.sv @@
// Shared types, constants and codes of the stable priority queue scheduler.
package spq_pkg;

  // Queue size and the widths that follow from it.
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned IdxW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  // Fixed field widths of the request and response.
  localparam int unsigned TagW   = 32;
  localparam int unsigned OwnerW = 16;
  localparam int unsigned UrgW   = 3;
  localparam int unsigned FuelW  = 7;
  localparam int unsigned PosW   = 5;
  localparam int unsigned TotalW = 32;

  // Limits applied to an entry on enqueue.
  localparam logic [UrgW-1:0]  UrgMin  = UrgW'(1);
  localparam logic [UrgW-1:0]  UrgMax  = UrgW'(4);
  localparam logic [FuelW-1:0] FuelMax = FuelW'(100);

  typedef enum logic [1:0] {
    CmdEnqueue = 2'd0,
    CmdDequeue = 2'd1,
    CmdPeek    = 2'd2,
    CmdSearch  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StsQueued   = 3'd0,
    StsFull     = 3'd1,
    StsServed   = 3'd2,
    StsEmpty    = 3'd3,
    StsHead     = 3'd4,
    StsFound    = 3'd5,
    StsNotFound = 3'd6
  } status_e;

  typedef enum logic {
    StIdle,
    StSearch
  } state_e;

  // One stored entry.
  typedef struct packed {
    logic [TagW-1:0]   tag;
    logic [OwnerW-1:0] owner;
    logic              op;
    logic [UrgW-1:0]   urg;
    logic [FuelW-1:0]  fuel;
  } entry_t;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic            enq;
    logic            deq;
    entry_t          new_entry;
    logic [TagW-1:0] key;
  } cell_ctrl_t;

endpackage

@@ rtl/spq_if.sv @@
// Request and response channel interfaces of the priority queue scheduler.
interface spq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] flight_tag;
  logic [15:0] owner_tag;
  logic        operation;
  logic [2:0]  urgency;
  logic [6:0]  fuel_percent;

  modport source (
    output valid, command, flight_tag, owner_tag, operation, urgency, fuel_percent,
    input  ready
  );
  modport sink (
    input  valid, command, flight_tag, owner_tag, operation, urgency, fuel_percent,
    output ready
  );
endinterface

interface spq_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] entry_tag;
  logic [15:0] entry_owner;
  logic        entry_operation;
  logic [2:0]  entry_urgency;
  logic [6:0]  entry_fuel;
  logic [4:0]  position;
  logic [4:0]  entry_count;
  logic [31:0] served_total;

  modport source (
    output valid, status, entry_tag, entry_owner, entry_operation, entry_urgency,
           entry_fuel, position, entry_count, served_total,
    input  ready
  );
  modport sink (
    input  valid, status, entry_tag, entry_owner, entry_operation, entry_urgency,
           entry_fuel, position, entry_count, served_total,
    output ready
  );
endinterface

@@ rtl/stable_priority_queue_scheduler.sv @@
// Top level of the stable priority queue scheduler: cell chain, control and response register.
// Enqueue, dequeue and peek give their response in the cycle after the request is accepted;
// a search first registers the per-cell tag compares, then picks the first match into the
// response register. Throughput: one request per cycle while responses are taken; no new
// request is taken while a search is pending. Reset clears the occupancy, the valid bit of
// every cell and the served counter at once; there is no clearing pass.
module stable_priority_queue_scheduler (
  input  logic             clk_i,
  input  logic             rst_ni,
  spq_req_if.sink          req_i,
  spq_rsp_if.source        rsp_o
);
  import spq_pkg::*;

  state_e               state_q, state_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [TotalW-1:0]    served_q, served_d;
  logic [QueueDepth-1:0] match_q;
  logic [QueueDepth-1:0] match_d;
  logic [QueueDepth-1:0] cell_valid;
  logic [QueueDepth-1:0] cell_before;
  entry_t               cell_entry [QueueDepth];
  cell_ctrl_t           ctrl;

  logic                 rsp_valid_q, rsp_valid_d;
  status_e              rsp_status_q, rsp_status_d;
  entry_t               rsp_entry_q, rsp_entry_d;
  logic [PosW-1:0]      rsp_pos_q, rsp_pos_d;
  logic [PosW-1:0]      rsp_cnt_q, rsp_cnt_d;

  logic                 accept;
  logic                 full;
  logic                 empty;
  logic                 found;
  logic [IdxW-1:0]      found_idx;
  logic [IdxW:0]        found_pos;
  cmd_e                 cmd;
  entry_t               new_entry;

  assign cmd   = cmd_e'(req_i.command);
  assign full  = (cnt_q == CntW'(QueueDepth));
  assign empty = (cnt_q == '0);

  // A request is taken when idle and the response register is free or draining.
  assign req_i.ready = (state_q == StIdle) && (!rsp_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  // Clamp urgency and fuel of the incoming entry.
  always_comb begin
    new_entry.tag   = req_i.flight_tag;
    new_entry.owner = req_i.owner_tag;
    new_entry.op    = req_i.operation;
    new_entry.urg   = req_i.urgency;
    new_entry.fuel  = req_i.fuel_percent;
    if (req_i.urgency < UrgMin) begin
      new_entry.urg = UrgMin;
    end else if (req_i.urgency > UrgMax) begin
      new_entry.urg = UrgMax;
    end
    if (req_i.fuel_percent > FuelMax) begin
      new_entry.fuel = FuelMax;
    end
  end

  // Broadcast control to the cell chain.
  always_comb begin
    ctrl.enq       = accept && (cmd == CmdEnqueue) && !full;
    ctrl.deq       = accept && (cmd == CmdDequeue) && !empty;
    ctrl.new_entry = new_entry;
    ctrl.key       = req_i.flight_tag;
  end

  // The chain of cells; the head sits in cell zero.
  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    logic   left_valid;
    entry_t left_entry;
    logic   left_before;
    logic   right_valid;
    entry_t right_entry;

    if (i == 0) begin : g_head
      assign left_valid  = 1'b0;
      assign left_entry  = new_entry;
      assign left_before = 1'b0;
    end else begin : g_mid
      assign left_valid  = cell_valid[i-1];
      assign left_entry  = cell_entry[i-1];
      assign left_before = cell_before[i-1];
    end

    if (i == QueueDepth - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_entry = cell_entry[i];
    end else begin : g_body
      assign right_valid = cell_valid[i+1];
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .left_valid_i  (left_valid),
      .left_entry_i  (left_entry),
      .left_before_i (left_before),
      .right_valid_i (right_valid),
      .right_entry_i (right_entry),
      .valid_o       (cell_valid[i]),
      .entry_o       (cell_entry[i]),
      .before_o      (cell_before[i]),
      .match_o       (match_d[i])
    );
  end

  // First match among the registered compare results.
  spq_search u_search (
    .match_i (match_q),
    .found_o (found),
    .index_o (found_idx)
  );

  assign found_pos = {1'b0, found_idx} + (IdxW + 1)'(1);

  // Sequencing and response generation.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    served_d     = served_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_entry_d  = rsp_entry_q;
    rsp_pos_d    = rsp_pos_q;
    rsp_cnt_d    = rsp_cnt_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          rsp_entry_d = '0;
          rsp_pos_d   = '0;
          case (cmd)
            CmdEnqueue: begin
              rsp_valid_d = 1'b1;
              if (full) begin
                rsp_status_d = StsFull;
              end else begin
                rsp_status_d = StsQueued;
                cnt_d        = cnt_q + CntW'(1);
              end
            end
            CmdDequeue: begin
              rsp_valid_d = 1'b1;
              if (empty) begin
                rsp_status_d = StsEmpty;
              end else begin
                rsp_status_d = StsServed;
                rsp_entry_d  = cell_entry[0];
                cnt_d        = cnt_q - CntW'(1);
                served_d     = served_q + TotalW'(1);
              end
            end
            CmdPeek: begin
              rsp_valid_d = 1'b1;
              if (empty) begin
                rsp_status_d = StsEmpty;
              end else begin
                rsp_status_d = StsHead;
                rsp_entry_d  = cell_entry[0];
              end
            end
            default: begin
              state_d = StSearch;
            end
          endcase
          rsp_cnt_d = PosW'(cnt_d);
        end
      end
      StSearch: begin
        state_d     = StIdle;
        rsp_valid_d = 1'b1;
        rsp_cnt_d   = PosW'(cnt_q);
        if (found) begin
          rsp_status_d = StsFound;
          rsp_entry_d  = cell_entry[found_idx];
          rsp_pos_d    = PosW'(found_pos);
        end else begin
          rsp_status_d = StsNotFound;
          rsp_entry_d  = '0;
          rsp_pos_d    = '0;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      served_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      served_q    <= served_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers: compare vector and response fields.
  always_ff @(posedge clk_i) begin
    match_q      <= match_d;
    rsp_status_q <= rsp_status_d;
    rsp_entry_q  <= rsp_entry_d;
    rsp_pos_q    <= rsp_pos_d;
    rsp_cnt_q    <= rsp_cnt_d;
  end

  // The served total is shown as it stands after the reported request.
  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.status          = rsp_status_q;
  assign rsp_o.entry_tag       = rsp_entry_q.tag;
  assign rsp_o.entry_owner     = rsp_entry_q.owner;
  assign rsp_o.entry_operation = rsp_entry_q.op;
  assign rsp_o.entry_urgency   = rsp_entry_q.urg;
  assign rsp_o.entry_fuel      = rsp_entry_q.fuel;
  assign rsp_o.position        = rsp_pos_q;
  assign rsp_o.entry_count     = rsp_cnt_q;
  assign rsp_o.served_total    = served_q;

endmodule

@@ rtl/spq_cell.sv @@
// One cell of the sorted shift-register queue.
module spq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic                left_valid_i,
  input  spq_pkg::entry_t     left_entry_i,
  input  logic                left_before_i,
  input  logic                right_valid_i,
  input  spq_pkg::entry_t     right_entry_i,
  output logic                valid_o,
  output spq_pkg::entry_t     entry_o,
  output logic                before_o,
  output logic                match_o
);
  import spq_pkg::*;

  logic   valid_q, valid_d;
  entry_t entry_q, entry_d;

  // The new entry belongs in front of this cell if the cell is empty or
  // strictly less urgent, which keeps equal urgencies in arrival order.
  assign before_o = !valid_q || (entry_q.urg > ctrl_i.new_entry.urg);
  assign match_o  = valid_q && (entry_q.tag == ctrl_i.key);
  assign valid_o  = valid_q;
  assign entry_o  = entry_q;

  // Next content: shift right on insert, shift left on removal.
  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (ctrl_i.enq) begin
      if (left_before_i) begin
        valid_d = left_valid_i;
        entry_d = left_entry_i;
      end else if (before_o) begin
        valid_d = 1'b1;
        entry_d = ctrl_i.new_entry;
      end
    end else if (ctrl_i.deq) begin
      valid_d = right_valid_i;
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

@@ rtl/spq_search.sv @@
// Priority encoder that finds the first matching cell from the head.
module spq_search (
  input  logic [spq_pkg::QueueDepth-1:0] match_i,
  output logic                           found_o,
  output logic [spq_pkg::IdxW-1:0]       index_o
);
  import spq_pkg::*;

  // Scan from the tail down so that the lowest set bit wins.
  always_comb begin
    found_o = 1'b0;
    index_o = '0;
    for (int i = QueueDepth - 1; i >= 0; i--) begin
      if (match_i[i]) begin
        found_o = 1'b1;
        index_o = IdxW'(i);
      end
    end
  end

endmodule

@@ sim/spq_checker.sv @@
// Checker for the priority queue scheduler: predicts every response and compares it.
module spq_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  spq_req_if          req_mon_i,
  spq_rsp_if          rsp_mon_i,
  output int unsigned fail_count_o,
  output int unsigned outstanding_o,
  output int unsigned checked_o,
  output logic [7:0]  status_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  // One predicted response, laid out as the response channel.
  typedef struct packed {
    status_e           status;
    logic [TagW-1:0]   tag;
    logic [OwnerW-1:0] owner;
    logic              op;
    logic [UrgW-1:0]   urg;
    logic [FuelW-1:0]  fuel;
    logic [PosW-1:0]   pos;
    logic [PosW-1:0]   count;
    logic [TotalW-1:0] served;
  } response_t;

  // Shadow of the queue contents, head first, and of the served counter.
  entry_t            shadow_queue[$];
  logic [TotalW-1:0] shadow_served = '0;

  // Responses owed by the block, oldest first.
  response_t   owed_responses[$];
  response_t   oldest;
  int unsigned fails   = 0;
  int unsigned checked = 0;
  logic [7:0]  seen    = '0;

  // Apply one request to the shadow queue and work out the response it causes.
  function automatic response_t apply_request(cmd_e cmd, logic [TagW-1:0] tag,
                                              logic [OwnerW-1:0] owner, logic op,
                                              logic [UrgW-1:0] urg, logic [FuelW-1:0] fuel);
    response_t r;
    entry_t    e;
    int        slot;
    bit        shows_entry;
    r           = '0;
    e           = '0;
    shows_entry = 1'b0;
    case (cmd)
      CmdEnqueue: begin
        if (shadow_queue.size() >= QueueDepth) begin
          r.status = StsFull;
        end else begin
          e.tag   = tag;
          e.owner = owner;
          e.op    = op;
          e.urg   = (urg < UrgMin) ? UrgMin : ((urg > UrgMax) ? UrgMax : urg);
          e.fuel  = (fuel > FuelMax) ? FuelMax : fuel;
          // The new entry goes behind every entry of equal or higher urgency.
          slot = 0;
          while (slot < shadow_queue.size() && shadow_queue[slot].urg <= e.urg) slot++;
          shadow_queue.insert(slot, e);
          r.status = StsQueued;
        end
      end
      CmdDequeue: begin
        if (shadow_queue.size() == 0) begin
          r.status = StsEmpty;
        end else begin
          e             = shadow_queue.pop_front();
          shadow_served = shadow_served + 1'b1;
          r.status      = StsServed;
          shows_entry   = 1'b1;
        end
      end
      CmdPeek: begin
        if (shadow_queue.size() == 0) begin
          r.status = StsEmpty;
        end else begin
          e           = shadow_queue[0];
          r.status    = StsHead;
          shows_entry = 1'b1;
        end
      end
      default: begin
        // Search from the head; the first matching tag wins.
        r.status = StsNotFound;
        for (slot = 0; slot < shadow_queue.size(); slot++) begin
          if (shadow_queue[slot].tag == tag) begin
            e           = shadow_queue[slot];
            r.status    = StsFound;
            r.pos       = PosW'(slot + 1);
            shows_entry = 1'b1;
            break;
          end
        end
      end
    endcase
    if (shows_entry) begin
      r.tag   = e.tag;
      r.owner = e.owner;
      r.op    = e.op;
      r.urg   = e.urg;
      r.fuel  = e.fuel;
    end
    r.count  = PosW'(shadow_queue.size());
    r.served = shadow_served;
    return r;
  endfunction

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0d ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      fails++;
    end
  endtask

  // Responses are checked before requests are applied: a response never belongs to a
  // request accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_queue.delete();
      owed_responses.delete();
      shadow_served = '0;
      fail_count_o  <= 0;
      outstanding_o <= 0;
      checked_o     <= 0;
      status_seen_o <= '0;
    end else begin
      if (rsp_mon_i.valid === 1'b1 && rsp_mon_i.ready === 1'b1) begin
        checked++;
        seen[rsp_mon_i.status] = 1'b1;
        if (owed_responses.size() == 0) begin
          $display("%0d ns: response with status 0x%0h arrived with none expected",
                   $time, rsp_mon_i.status);
          fails++;
        end else begin
          oldest = owed_responses.pop_front();
          compare_field("status", 32'(oldest.status), 32'(rsp_mon_i.status));
          compare_field("entry_tag", oldest.tag, rsp_mon_i.entry_tag);
          compare_field("entry_owner", 32'(oldest.owner), 32'(rsp_mon_i.entry_owner));
          compare_field("entry_operation", 32'(oldest.op), 32'(rsp_mon_i.entry_operation));
          compare_field("entry_urgency", 32'(oldest.urg), 32'(rsp_mon_i.entry_urgency));
          compare_field("entry_fuel", 32'(oldest.fuel), 32'(rsp_mon_i.entry_fuel));
          compare_field("position", 32'(oldest.pos), 32'(rsp_mon_i.position));
          compare_field("entry_count", 32'(oldest.count), 32'(rsp_mon_i.entry_count));
          compare_field("served_total", oldest.served, rsp_mon_i.served_total);
        end
      end
      if (req_mon_i.valid === 1'b1 && req_mon_i.ready === 1'b1) begin
        owed_responses.push_back(apply_request(cmd_e'(req_mon_i.command), req_mon_i.flight_tag,
                                               req_mon_i.owner_tag, req_mon_i.operation,
                                               req_mon_i.urgency, req_mon_i.fuel_percent));
      end
      fail_count_o  <= fails;
      outstanding_o <= owed_responses.size();
      checked_o     <= checked;
      status_seen_o <= seen;
    end
  end

endmodule

@@ sim/stable_priority_queue_scheduler_tb.sv @@
// Testbench top of the priority queue scheduler: clock, reset, request stimulus and verdict.
module stable_priority_queue_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int unsigned LongHold    = 80;
  localparam int unsigned Segments    = 18;
  localparam int unsigned SegmentLen  = 30;
  localparam int unsigned HoldSegment = 4;
  localparam int unsigned DrainBefore = 9;
  localparam int unsigned CalmFrom    = 15;

  // Command mix of one stretch of random requests.
  typedef enum int {
    MixFill,
    MixBalanced,
    MixDrain,
    MixSearch
  } mix_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  spq_req_if req_if ();
  spq_rsp_if rsp_if ();

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned checked;
  logic [7:0]  status_seen;

  // Run flags and request counts; calm and hold_rsp are shared with the response process.
  bit          calm      = 1'b0;
  bit          hold_rsp  = 1'b0;
  bit          no_tx_gap = 1'b0;
  int unsigned sent_total;
  int unsigned sent_directed;

  // Tags recently enqueued, used as search keys so that searches hit.
  logic [TagW-1:0] recent_tags[16];
  int unsigned     recent_wr = 0;

  always #4 clk_i = ~clk_i;

  stable_priority_queue_scheduler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  spq_checker checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_mon_i     (req_if),
    .rsp_mon_i     (rsp_if),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .checked_o     (checked),
    .status_seen_o (status_seen)
  );

  // Offer one request and hold it until the block takes it.
  task automatic send_request(cmd_e cmd, logic [TagW-1:0] tag, logic [OwnerW-1:0] owner,
                              logic op, logic [UrgW-1:0] urg, logic [FuelW-1:0] fuel);
    req_if.valid        <= 1'b1;
    req_if.command      <= cmd;
    req_if.flight_tag   <= tag;
    req_if.owner_tag    <= owner;
    req_if.operation    <= op;
    req_if.urgency      <= urg;
    req_if.fuel_percent <= fuel;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sent_total++;
    if (cmd == CmdEnqueue) begin
      recent_tags[recent_wr] = tag;
      recent_wr = (recent_wr + 1) % 16;
    end
  endtask

  // Occasional burst of idle cycles on the request side.
  task automatic maybe_pause();
    if (!calm && !no_tx_gap && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // Stop offering requests until every owed response has arrived.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // One random request; the mix decides how likely each command is.
  task automatic random_request(mix_e mix);
    int unsigned     pick;
    int unsigned     shape;
    cmd_e            cmd;
    logic [TagW-1:0] tag;
    logic [UrgW-1:0] urg;
    logic [FuelW-1:0] fuel;
    pick = $urandom_range(0, 99);
    case (mix)
      MixFill:  cmd = (pick < 80) ? CmdEnqueue : (pick < 88) ? CmdDequeue :
                      (pick < 94) ? CmdPeek : CmdSearch;
      MixDrain: cmd = (pick < 15) ? CmdEnqueue : (pick < 80) ? CmdDequeue :
                      (pick < 88) ? CmdPeek : CmdSearch;
      MixSearch: cmd = (pick < 25) ? CmdEnqueue : (pick < 40) ? CmdDequeue :
                       (pick < 50) ? CmdPeek : CmdSearch;
      default:  cmd = (pick < 40) ? CmdEnqueue : (pick < 65) ? CmdDequeue :
                      (pick < 75) ? CmdPeek : CmdSearch;
    endcase
    // A small pool of tags makes duplicates, so the first match matters.
    shape = $urandom_range(0, 9);
    if (shape < 3) tag = $urandom_range(1, 6);
    else if (shape == 3) tag = $urandom_range(0, 1) ? '1 : '0;
    else tag = $urandom;
    if (cmd == CmdSearch && $urandom_range(0, 99) < 65) tag = recent_tags[$urandom_range(0, 15)];
    urg  = ($urandom_range(0, 4) == 0) ? UrgW'($urandom_range(0, 7)) : UrgW'($urandom_range(1, 4));
    fuel = ($urandom_range(0, 6) == 0) ? FuelW'($urandom_range(101, 127))
                                       : FuelW'($urandom_range(0, 100));
    send_request(cmd, tag, OwnerW'($urandom), 1'($urandom), urg, fuel);
  endtask

  // Response side: random stalls, one long hold on request, none in the calm part.
  initial begin
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
        hold_rsp = 1'b0;
        repeat (LongHold - 1) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(0, 14)) @(posedge clk_i);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Request stimulus and verdict.
  initial begin
    req_if.valid        <= 1'b0;
    req_if.command      <= CmdEnqueue;
    req_if.flight_tag   <= '0;
    req_if.owner_tag    <= '0;
    req_if.operation    <= 1'b0;
    req_if.urgency      <= '0;
    req_if.fuel_percent <= '0;
    foreach (recent_tags[i]) recent_tags[i] = '0;
    sent_total = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty queue: peek, dequeue and search all report nothing.
    send_request(CmdPeek, '0, '0, 1'b0, '0, '0);
    send_request(CmdDequeue, '1, '1, 1'b1, 3'd7, 7'd127);
    send_request(CmdSearch, '0, '0, 1'b0, '0, '0);
    // Field extremes, with urgency and fuel outside their ranges.
    send_request(CmdEnqueue, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 3'd7, 7'd127);
    send_request(CmdEnqueue, 32'h0000_0000, 16'h0000, 1'b0, 3'd0, 7'd0);
    send_request(CmdEnqueue, 32'hA5A5_A5A5, 16'h5A5A, 1'b1, 3'd4, 7'd100);
    send_request(CmdEnqueue, 32'h5A5A_5A5A, 16'hA5A5, 1'b0, 3'd1, 7'd101);
    send_request(CmdEnqueue, 32'h0000_0012, 16'h0001, 1'b1, 3'd5, 7'd50);
    send_request(CmdEnqueue, 32'h0000_0012, 16'h0002, 1'b0, 3'd2, 7'd99);
    send_request(CmdEnqueue, 32'h0000_0034, 16'h8000, 1'b1, 3'd3, 7'd1);
    // Head, duplicate tag, an entry further back, a miss and the head found by tag.
    send_request(CmdPeek, '0, '0, 1'b0, '0, '0);
    send_request(CmdSearch, 32'h0000_0012, '0, 1'b0, '0, '0);
    send_request(CmdSearch, 32'hFFFF_FFFF, '0, 1'b0, '0, '0);
    send_request(CmdSearch, 32'h0000_7777, '1, 1'b1, 3'd7, 7'd127);
    send_request(CmdSearch, 32'h0000_0000, '0, 1'b0, '0, '0);
    send_request(CmdDequeue, '0, '0, 1'b0, '0, '0);
    send_request(CmdDequeue, '0, '0, 1'b0, '0, '0);
    send_request(CmdPeek, 32'h1234_5678, 16'h4321, 1'b1, 3'd6, 7'd110);
    sent_directed = sent_total;

    // Random stretches cycling through fill, mixed, drain and search-heavy mixes.
    for (int seg = 0; seg < Segments; seg++) begin
      if (seg == DrainBefore) wait_drained();
      calm      = (seg >= CalmFrom);
      no_tx_gap = (seg == HoldSegment);
      if (seg == HoldSegment) hold_rsp = 1'b1;
      for (int n = 0; n < SegmentLen; n++) begin
        random_request(mix_e'(seg % 4));
        maybe_pause();
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Run covered %0d requests (%0d directed) and %0d responses, with a full queue,",
             sent_total, sent_directed, checked);
    $display("an empty queue and duplicate tags; status codes seen (bit per code): %b",
             status_seen);
    if (fail_count == 0) begin
      $display("stable_priority_queue_scheduler test passed");
    end else begin
      $display("stable_priority_queue_scheduler test failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("Timeout with %0d responses still owed", outstanding);
    $display("stable_priority_queue_scheduler test failed");
    $finish;
  end

endmodule
